// ===== hw/rtl/cle_pkg.sv =====
// ----------------------------------------------------------------------------
// Console line editor package
// Shared constants, codes and the command word passed from front to back.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int BUFFER_DEPTH = 1024;
  localparam int MAX_READ     = 64;
  localparam int PTR_W        = $clog2(BUFFER_DEPTH);
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int RC_W         = 7;
  localparam int WIDE_W       = (CNT_W > RC_W) ? CNT_W : RC_W;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_EDITING = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KBD_INTERCEPT = 1'd1;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_DEL = 8'h7F;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_DATA = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CMD_CHAR = 3'd0,
    CMD_NL   = 3'd1,
    CMD_BS   = 3'd2,
    CMD_RAW  = 3'd3,
    CMD_READ = 3'd4
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t         op;
    logic [7:0]      data;
    logic [RC_W-1:0] want;
  } cmd_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    ptr_dec = (p == '0) ? PTR_W'(BUFFER_DEPTH - 1) : p - 1'b1;
  endfunction

endpackage

// ===== hw/rtl/cle_queue.sv =====
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module cle_queue import cle_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t cmd_in,
  output logic full,
  input  logic pop,
  output cmd_t cmd_out,
  output logic empty
);

  cmd_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign cmd_out = slot_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= cmd_in;
    end
  end

endmodule

// ===== hw/rtl/cle_front.sv =====
// ----------------------------------------------------------------------------
// Front end
// Holds the mode registers, accepts words and classifies them into commands.
// ----------------------------------------------------------------------------
module cle_front import cle_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [7:0]           in_key_byte,
  input  logic [RC_W-1:0]      in_read_count,
  input  logic                 q_full,
  output logic                 q_push,
  output cmd_t                 q_cmd
);

  logic line_editing_r, line_editing_nxt;
  logic kbd_int_r, kbd_int_nxt;

  always_comb begin
    line_editing_nxt = line_editing_r;
    kbd_int_nxt      = kbd_int_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_LINE_EDITING:  line_editing_nxt = cfg_wdata;
        CFG_KBD_INTERCEPT: kbd_int_nxt      = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_editing_r <= 1'b1;
      kbd_int_r      <= 1'b0;
    end else begin
      line_editing_r <= line_editing_nxt;
      kbd_int_r      <= kbd_int_nxt;
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Read counts are clamped here so the back end sees 1 to MAX_READ.
  always_comb begin
    q_cmd.data = in_key_byte;
    q_cmd.want = in_read_count;
    if (in_read_count == '0) begin
      q_cmd.want = RC_W'(1);
    end else if (in_read_count > RC_W'(MAX_READ)) begin
      q_cmd.want = RC_W'(MAX_READ);
    end
    if (in_op) begin
      q_cmd.op = CMD_READ;
    end else if (!line_editing_r) begin
      q_cmd.op = CMD_RAW;
      if (!kbd_int_r && in_key_byte == CH_BS) begin
        q_cmd.data = CH_DEL;
      end
    end else if (in_key_byte == CH_CR || in_key_byte == CH_LF) begin
      q_cmd.op = CMD_NL;
    end else if (in_key_byte == CH_BS || in_key_byte == CH_DEL) begin
      q_cmd.op = CMD_BS;
    end else begin
      q_cmd.op = CMD_CHAR;
    end
  end

endmodule

// ===== hw/rtl/cle_back.sv =====
// ----------------------------------------------------------------------------
// Back end
// Owns both byte stores as circular buffers and sequences echoes, line
// commits and reads into the output register.
// ----------------------------------------------------------------------------
module cle_back import cle_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       q_cmd,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_last
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_ECHO    = 6'b000010,
    ST_COPY_RD = 6'b000100,
    ST_COPY_WR = 6'b001000,
    ST_READ_RD = 6'b010000,
    ST_READ_WR = 6'b100000
  } state_t;

  localparam logic [CNT_W-1:0] FULL = CNT_W'(BUFFER_DEPTH);

  logic [7:0] edit_mem [BUFFER_DEPTH];
  logic [7:0] line_mem [BUFFER_DEPTH];

  state_t           state_r, state_nxt;
  logic [PTR_W-1:0] eh_r, eh_nxt, et_r, et_nxt;
  logic [PTR_W-1:0] lh_r, lh_nxt, lt_r, lt_nxt;
  logic [CNT_W-1:0] ec_r, ec_nxt, lc_r, lc_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             commit_r, commit_nxt;
  kind_t            emit_kind_r, emit_kind_nxt;
  logic [7:0]       em0_r, em0_nxt, em1_r, em1_nxt, em2_r, em2_nxt;
  logic [1:0]       emit_cnt_r, emit_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  kind_t            out_kind_r, out_kind_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic [7:0]       edit_rd_r, line_rd_r;

  logic             edit_we, line_we;
  logic [PTR_W-1:0] line_wa;
  logic [7:0]       edit_wd, line_wd;
  logic             out_free, out_load;
  logic [CNT_W-1:0] ec_after, line_free, move_n, read_n;
  logic [WIDE_W-1:0] want_w, lc_w;

  assign out_free  = !out_valid_r || out_ready;
  assign ec_after  = (ec_r < FULL) ? ec_r + 1'b1 : ec_r;
  assign line_free = FULL - lc_r;
  assign move_n    = (ec_after < line_free) ? ec_after : line_free;
  assign want_w    = WIDE_W'(q_cmd.want);
  assign lc_w      = WIDE_W'(lc_r);
  assign read_n    = CNT_W'((want_w < lc_w) ? want_w : lc_w);

  always_comb begin
    state_nxt     = state_r;
    eh_nxt        = eh_r;
    et_nxt        = et_r;
    lh_nxt        = lh_r;
    lt_nxt        = lt_r;
    ec_nxt        = ec_r;
    lc_nxt        = lc_r;
    rem_nxt       = rem_r;
    commit_nxt    = commit_r;
    emit_kind_nxt = emit_kind_r;
    em0_nxt       = em0_r;
    em1_nxt       = em1_r;
    em2_nxt       = em2_r;
    emit_cnt_nxt  = emit_cnt_r;
    q_pop         = 1'b0;
    edit_we       = 1'b0;
    edit_wd       = q_cmd.data;
    line_we       = 1'b0;
    line_wa       = lt_r;
    line_wd       = q_cmd.data;
    out_load      = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop         = 1'b1;
          emit_kind_nxt = KIND_ECHO;
          commit_nxt    = 1'b0;
          case (q_cmd.op)
            CMD_CHAR: begin
              if (ec_r < FULL) begin
                edit_we      = 1'b1;
                et_nxt       = ptr_inc(et_r);
                ec_nxt       = ec_r + 1'b1;
                em0_nxt      = q_cmd.data;
                emit_cnt_nxt = 2'd1;
                state_nxt    = ST_ECHO;
              end
            end
            CMD_BS: begin
              if (ec_r != '0) begin
                et_nxt       = ptr_dec(et_r);
                ec_nxt       = ec_r - 1'b1;
                em0_nxt      = CH_BS;
                em1_nxt      = CH_SP;
                em2_nxt      = CH_BS;
                emit_cnt_nxt = 2'd3;
                state_nxt    = ST_ECHO;
              end
            end
            CMD_NL: begin
              rem_nxt    = move_n;
              commit_nxt = (move_n != '0);
              if (ec_r < FULL) begin
                edit_we      = 1'b1;
                edit_wd      = CH_LF;
                et_nxt       = ptr_inc(et_r);
                ec_nxt       = ec_after;
                em0_nxt      = CH_CR;
                em1_nxt      = CH_LF;
                emit_cnt_nxt = 2'd2;
                state_nxt    = ST_ECHO;
              end else if (move_n != '0) begin
                state_nxt = ST_COPY_RD;
              end
            end
            CMD_RAW: begin
              if (lc_r < FULL) begin
                line_we = 1'b1;
                lt_nxt  = ptr_inc(lt_r);
                lc_nxt  = lc_r + 1'b1;
              end
            end
            CMD_READ: begin
              if (lc_r == '0) begin
                emit_kind_nxt = KIND_NONE;
                em0_nxt       = 8'h00;
                emit_cnt_nxt  = 2'd1;
                state_nxt     = ST_ECHO;
              end else begin
                rem_nxt   = read_n;
                state_nxt = ST_READ_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ECHO: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_kind_nxt = emit_kind_r;
          out_byte_nxt = em0_r;
          out_last_nxt = (emit_cnt_r == 2'd1);
          em0_nxt      = em1_r;
          em1_nxt      = em2_r;
          emit_cnt_nxt = emit_cnt_r - 2'd1;
          if (emit_cnt_r == 2'd1) begin
            state_nxt = commit_r ? ST_COPY_RD : ST_IDLE;
          end
        end
      end
      ST_COPY_RD: begin
        state_nxt = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        line_we   = 1'b1;
        line_wd   = edit_rd_r;
        lt_nxt    = ptr_inc(lt_r);
        lc_nxt    = lc_r + 1'b1;
        eh_nxt    = ptr_inc(eh_r);
        ec_nxt    = ec_r - 1'b1;
        rem_nxt   = rem_r - 1'b1;
        state_nxt = (rem_r == CNT_W'(1)) ? ST_IDLE : ST_COPY_RD;
      end
      ST_READ_RD: begin
        state_nxt = ST_READ_WR;
      end
      ST_READ_WR: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_kind_nxt = KIND_DATA;
          out_byte_nxt = line_rd_r;
          out_last_nxt = (rem_r == CNT_W'(1));
          lh_nxt       = ptr_inc(lh_r);
          lc_nxt       = lc_r - 1'b1;
          rem_nxt      = rem_r - 1'b1;
          state_nxt    = (rem_r == CNT_W'(1)) ? ST_IDLE : ST_READ_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      eh_r        <= '0;
      et_r        <= '0;
      lh_r        <= '0;
      lt_r        <= '0;
      ec_r        <= '0;
      lc_r        <= '0;
      rem_r       <= '0;
      commit_r    <= 1'b0;
      emit_cnt_r  <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      eh_r        <= eh_nxt;
      et_r        <= et_nxt;
      lh_r        <= lh_nxt;
      lt_r        <= lt_nxt;
      ec_r        <= ec_nxt;
      lc_r        <= lc_nxt;
      rem_r       <= rem_nxt;
      commit_r    <= commit_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    emit_kind_r <= emit_kind_nxt;
    em0_r       <= em0_nxt;
    em1_r       <= em1_nxt;
    em2_r       <= em2_nxt;
    out_kind_r  <= out_kind_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Edit store: written at the tail, read at the head.
  always_ff @(posedge clk) begin
    if (edit_we) begin
      edit_mem[et_r] <= edit_wd;
    end
    edit_rd_r <= edit_mem[eh_r];
  end

  // Line store: written at the tail, read at the head.
  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[line_wa] <= line_wd;
    end
    line_rd_r <= line_mem[lh_r];
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

// ===== hw/rtl/console_line_editor.sv =====
// ----------------------------------------------------------------------------
// Console line editor
// Canonical-mode line discipline with an edit store and a line store.
// ----------------------------------------------------------------------------
// Path: a word is registered in the queue, popped by the back end, then loaded
//   into the output register from the echo state, or after a line-store read.
// Sequencing (back end): a raw key is stored at the pop, a printable key echoes
//   one byte, a backspace three, CR or LF two plus one edit-store read and one
//   line-store write per byte committed, a read one store read and output load per byte.
// Reset: synchronous, active low; counts and pointers clear, modes take their defaults.
module console_line_editor import cle_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [7:0]           in_key_byte,
  input  logic [RC_W-1:0]      in_read_count,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_kind,
  output logic [7:0]           out_byte,
  output logic                 out_last
);

  // The front end classifies each word against the current mode: editing
  // keys become append, newline or erase commands, raw keys are mapped (BS to
  // DEL unless intercepted) and read counts are clamped to 1..MAX_READ.
  cmd_t front_cmd;
  cmd_t back_cmd;
  logic q_push, q_full, q_pop, q_empty;

  cle_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_key_byte   (in_key_byte),
    .in_read_count (in_read_count),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (front_cmd)
  );

  // A two-entry queue lets the front keep taking words while the back end
  // is busy copying a line or waiting on a stalled output.
  cle_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .cmd_in  (front_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .cmd_out (back_cmd),
    .empty   (q_empty)
  );

  // The back end keeps both stores as circular buffers, so removing bytes
  // from the front is a pointer step rather than a move of the contents.
  cle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_cmd     (back_cmd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  // The back end only takes a command that is there.
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command popped from an empty queue");

  // An empty-store answer is always a single, final, zero word.
  a_none_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_NONE) |-> (out_last && out_byte == 8'h00))
    else $error("nothing-available word malformed");

  // Only the three defined result kinds ever appear.
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_ECHO || out_kind == KIND_DATA ||
                   out_kind == KIND_NONE))
    else $error("undefined result kind");

endmodule
